### hw/rtl/rdsm_pkg.sv
// Shared types and constants for the dot-star pattern matcher.
package rdsm_pkg;

    // Default pattern capacity in tokens.
    localparam int MAX_TOKENS_DEF = 16;

    // Width of the token-count register.
    localparam int CNT_W = 5;

    // The '.' byte matches any text byte.
    localparam logic [7:0] DOT_BYTE = 8'd46;

    // Input operation codes, carried in s_tuser.
    typedef enum logic [1:0] {
        OP_WRITE_TOKEN = 2'd0,
        OP_TEXT_BYTE   = 2'd1,
        OP_EMPTY_TEXT  = 2'd2,
        OP_UNUSED      = 2'd3
    } op_t;

    // One pattern token: a byte plus its repeat flag.
    typedef struct packed {
        logic       star;
        logic [7:0] chr;
    } token_t;

    // Status of one evaluated beat, from the step logic to the top level.
    typedef struct packed {
        logic produce;
        logic matched;
    } step_res_t;

endpackage

### hw/rtl/regex_dot_star_matcher.sv
// Top level of the whole-string matcher for literal, '.' and '*' patterns.
//
//  channel  | signals                          | beat carries
//  ---------+----------------------------------+------------------------------------
//  s_axis   | s_tvalid s_tready s_tdata        | token write, text byte or empty test
//           | s_tuser s_tlast                  |
//  m_axis   | m_tvalid m_tready m_tdata        | match flag, one per finished string
//  cfg      | cfg_valid cfg_ready cfg_data     | number of pattern tokens in use
//
// One beat per cycle is taken while no result is stalled. A beat is held in the
// input register; the position-set update and the closure ripple over the pattern
// are combinational, and their result is loaded into the result register that
// drives m_tdata. Reset clears the token count and leaves only position zero
// active; the pattern store is not cleared. A stalled result holds the input
// register only when that register holds another result-producing beat; token
// writes and non-final bytes still drain.
module regex_dot_star_matcher #(
    parameter int MAX_TOKENS = rdsm_pkg::MAX_TOKENS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // Input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // [3:0] token_index, [11:4] token_char, [12] token_star,
    // [20:13] text_char, [23:21] zero
    input  logic [23:0]                s_tdata,
    // [1:0] operation
    input  logic [1:0]                 s_tuser,
    // last_char
    input  logic                       s_tlast,
    // Result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [0] matched, [7:1] zero
    output logic [7:0]                 m_tdata,
    // Token count register
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [rdsm_pkg::CNT_W-1:0] cfg_data
);

    // Input register stage.
    logic                  s1_valid_reg;
    rdsm_pkg::op_t         s1_op_reg;
    logic [3:0]            s1_index_reg;
    rdsm_pkg::token_t      s1_token_reg;
    logic [7:0]            s1_text_reg;
    logic                  s1_last_reg;

    // Matcher state.
    logic [rdsm_pkg::CNT_W-1:0] count_reg;
    logic [MAX_TOKENS:0]        active_reg;
    logic [MAX_TOKENS:0]        active_next;
    rdsm_pkg::token_t           store_reg [MAX_TOKENS];

    // Result register.
    logic                  out_valid_reg;
    logic                  out_matched_reg;

    rdsm_pkg::step_res_t   res;
    logic                  s1_advance;
    logic                  s_fire;

    rdsm_step #(
        .MAX_TOKENS (MAX_TOKENS)
    ) u_step (
        .op          (s1_op_reg),
        .text_char   (s1_text_reg),
        .last_char   (s1_last_reg),
        .token_count (count_reg),
        .tokens      (store_reg),
        .active      (active_reg),
        .active_next (active_next),
        .res         (res)
    );

    // Advance the input stage unless its result has nowhere to go.
    assign s1_advance = s1_valid_reg && (!res.produce || !out_valid_reg || m_tready);
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign s_fire     = s_tvalid && s_tready;

    assign cfg_ready  = 1'b1;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {7'd0, out_matched_reg};

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_op_reg     <= rdsm_pkg::OP_UNUSED;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            active_reg    <= {{MAX_TOKENS{1'b0}}, 1'b1};
        end
        else
        begin
            if (s_fire)
            begin
                s1_valid_reg <= 1'b1;
                s1_op_reg    <= rdsm_pkg::op_t'(s_tuser);
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_advance && res.produce)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (s1_advance)
            begin
                active_reg <= active_next;
            end

            if (cfg_valid)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    // Payload registers: capture the beat, load the result, write the pattern.
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_index_reg       <= s_tdata[3:0];
            s1_token_reg.chr   <= s_tdata[11:4];
            s1_token_reg.star  <= s_tdata[12];
            s1_text_reg        <= s_tdata[20:13];
            s1_last_reg        <= s_tlast;
        end

        if (s1_advance && res.produce)
        begin
            out_matched_reg <= res.matched;
        end

        // Drop token writes beyond the pattern capacity.
        for (int e = 0; e < MAX_TOKENS; e++)
        begin
            if (s1_advance && (s1_op_reg == rdsm_pkg::OP_WRITE_TOKEN)
                && (32'(s1_index_reg) == e))
            begin
                store_reg[e] <= s1_token_reg;
            end
        end
    end

endmodule

### hw/rtl/rdsm_step.sv
// Next-state logic of the position set: closure, byte step and final test.
module rdsm_step #(
    parameter int MAX_TOKENS = rdsm_pkg::MAX_TOKENS_DEF
) (
    input  rdsm_pkg::op_t             op,
    input  logic [7:0]                text_char,
    input  logic                      last_char,
    input  logic [rdsm_pkg::CNT_W-1:0] token_count,
    input  rdsm_pkg::token_t          tokens [MAX_TOKENS],
    input  logic [MAX_TOKENS:0]       active,
    output logic [MAX_TOKENS:0]       active_next,
    output rdsm_pkg::step_res_t       res
);

    // Ripple set bits forward across starred tokens that are in use.
    function automatic logic [MAX_TOKENS:0] close_pos(
        input logic [MAX_TOKENS:0]   set,
        input logic [MAX_TOKENS-1:0] star_use
    );
        logic [MAX_TOKENS:0] r;
        r = set;
        for (int i = 0; i < MAX_TOKENS; i++)
        begin
            if (r[i] && star_use[i])
            begin
                r[i + 1] = 1'b1;
            end
        end
        return r;
    endfunction

    logic [MAX_TOKENS-1:0] in_use;
    logic [MAX_TOKENS-1:0] star_use;
    logic [MAX_TOKENS-1:0] hit;
    logic [MAX_TOKENS:0]   at_n;
    logic [MAX_TOKENS:0]   keep;
    logic [MAX_TOKENS:0]   start_set;
    logic [MAX_TOKENS:0]   cur;
    logic [MAX_TOKENS:0]   nxt;
    logic [MAX_TOKENS:0]   fin;
    logic [MAX_TOKENS:0]   emp;
    logic                  fin_hit;
    logic                  emp_hit;

    assign start_set = {{MAX_TOKENS{1'b0}}, 1'b1};

    always_comb
    begin
        // Position masks against the clamped token count.
        for (int i = 0; i < MAX_TOKENS; i++)
        begin
            in_use[i]   = 32'(token_count) > i;
            star_use[i] = in_use[i] && tokens[i].star;
            hit[i]      = (tokens[i].chr == rdsm_pkg::DOT_BYTE) || (tokens[i].chr == text_char);
        end
        for (int i = 0; i <= MAX_TOKENS; i++)
        begin
            keep[i] = 32'(token_count) >= i;
            if (i == MAX_TOKENS)
            begin
                at_n[i] = 32'(token_count) >= MAX_TOKENS;
            end
            else
            begin
                at_n[i] = 32'(token_count) == i;
            end
        end

        cur = close_pos(active & keep, star_use);

        nxt = '0;
        for (int i = 0; i < MAX_TOKENS; i++)
        begin
            if (in_use[i] && cur[i] && hit[i])
            begin
                if (tokens[i].star)
                begin
                    nxt[i] = 1'b1;
                end
                else
                begin
                    nxt[i + 1] = 1'b1;
                end
            end
        end

        fin = close_pos(nxt, star_use);
        emp = close_pos(start_set, star_use);

        fin_hit = 1'b0;
        emp_hit = 1'b0;
        for (int i = 0; i <= MAX_TOKENS; i++)
        begin
            if (at_n[i])
            begin
                fin_hit = fin[i];
                emp_hit = emp[i];
            end
        end

        active_next = active;
        res         = '0;
        unique case (op)
            rdsm_pkg::OP_TEXT_BYTE:
            begin
                active_next = last_char ? start_set : nxt;
                res.produce = last_char;
                res.matched = fin_hit;
            end
            rdsm_pkg::OP_EMPTY_TEXT:
            begin
                active_next = start_set;
                res.produce = 1'b1;
                res.matched = emp_hit;
            end
            rdsm_pkg::OP_WRITE_TOKEN,
            rdsm_pkg::OP_UNUSED:
            begin
                active_next = active;
            end
        endcase
    end

endmodule
